@@ hw/rtl/fcba_pkg.sv @@
package fcba_pkg;

  // Table geometry and field widths.
  localparam int TABLE_DEPTH = 4096;
  localparam int IDX_W       = 12;
  localparam int CNT_W       = 13;
  localparam int DATA_W      = 32;
  localparam int ACT_W       = 3;
  localparam int STAT_W      = 2;

  // Reset value of the block count register.
  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(TABLE_DEPTH);

  // Special entry values.
  localparam logic [DATA_W-1:0] ENTRY_FREE   = '0;
  localparam logic [DATA_W-1:0] ENTRY_TAKEN  = DATA_W'(1);
  localparam logic [DATA_W-1:0] END_OF_CHAIN = '1;

  // Action codes carried by an input word.
  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD   = 3'd0,
    ACT_READ   = 3'd1,
    ACT_ALLOC  = 3'd2,
    ACT_LINK   = 3'd3,
    ACT_TERM   = 3'd4,
    ACT_CENSUS = 3'd5
  } action_t;

  // Status codes carried by a result word.
  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_RANGE  = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_SCAN,
    S_MARK,
    S_LINK,
    S_DONE
  } state_t;

endpackage

@@ hw/rtl/fat_chain_block_allocator.sv @@
// File allocation table block allocator.
//
// Input channel: in_valid / in_stall with action, block and value. A word is
// taken when in_valid is high and in_stall is low. The block works on one
// word at a time; in_stall is high from the cycle after a word is taken until
// its result has been placed in the output register.
// Output channel: out_valid / out_stall with status, found_index, entry_value
// and the three census counts. Every input word gives exactly one result word.
// The result waits in the output register while out_stall is high; a new
// input word can be taken meanwhile, but its result is not loaded until the
// waiting one has been taken.
// Load, terminate, unknown actions and out-of-range words go from execute
// straight to done; a read passes a wait state for the registered table read.
// Allocate, link and census walk the table one entry per cycle over at most n
// entries, where n is blocks_in_use limited to the table depth (4096). Without
// stalls a new word is taken in the cycle after a result loads.
// Configuration: cfg_wen writes cfg_wdata into blocks_in_use; write only
// while the block is idle. Reset sets blocks_in_use to 4096 and empties both
// channels; table contents are undefined until loaded, and no clearing pass
// is run.
module fat_chain_block_allocator (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration port.
  input  logic                              cfg_wen,
  input  logic [fcba_pkg::CNT_W-1:0]        cfg_wdata,
  // Input channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [fcba_pkg::ACT_W-1:0]        action,
  input  logic [fcba_pkg::IDX_W-1:0]        block,
  input  logic [fcba_pkg::DATA_W-1:0]       value,
  // Output channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [fcba_pkg::STAT_W-1:0]       status,
  output logic [fcba_pkg::IDX_W-1:0]        found_index,
  output logic [fcba_pkg::DATA_W-1:0]       entry_value,
  output logic [fcba_pkg::CNT_W-1:0]        free_count,
  output logic [fcba_pkg::CNT_W-1:0]        reserved_count,
  output logic [fcba_pkg::CNT_W-1:0]        allocated_count
);

  fcba_pkg::state_t state, state_next;

  // Configuration register and its limited value.
  logic [fcba_pkg::CNT_W-1:0]  blocks_in_use;
  logic [fcba_pkg::CNT_W-1:0]  eff_count;

  // Current word.
  logic [fcba_pkg::ACT_W-1:0]  act;
  logic [fcba_pkg::IDX_W-1:0]  blk;
  logic [fcba_pkg::DATA_W-1:0] val;

  // Scan control.
  logic [fcba_pkg::CNT_W-1:0]  cnt;
  logic                        rd_pending;
  logic [fcba_pkg::IDX_W-1:0]  rd_idx;

  // Result being built.
  logic [fcba_pkg::STAT_W-1:0] res_status;
  logic [fcba_pkg::IDX_W-1:0]  res_found;
  logic [fcba_pkg::DATA_W-1:0] res_entry;
  logic [fcba_pkg::CNT_W-1:0]  res_free;
  logic [fcba_pkg::CNT_W-1:0]  res_reserved;
  logic [fcba_pkg::CNT_W-1:0]  res_allocated;

  // Table memory and its ports.
  logic [fcba_pkg::DATA_W-1:0] mem [fcba_pkg::TABLE_DEPTH];
  logic [fcba_pkg::DATA_W-1:0] rd_data;
  logic                        mem_re;
  logic [fcba_pkg::IDX_W-1:0]  mem_raddr;
  logic                        mem_we;
  logic [fcba_pkg::IDX_W-1:0]  mem_waddr;
  logic [fcba_pkg::DATA_W-1:0] mem_wdata;

  // Decoded conditions.
  logic accept;
  logic in_range;
  logic is_alloc;
  logic is_census;
  logic range_fail;
  logic scan_issue;
  logic scan_hit;
  logic scan_end;
  logic out_take;
  logic out_load;

  assign accept    = (state == fcba_pkg::S_IDLE) && in_valid;
  assign in_stall  = (state != fcba_pkg::S_IDLE);
  assign eff_count = (blocks_in_use > fcba_pkg::COUNT_RESET) ? fcba_pkg::COUNT_RESET
                                                             : blocks_in_use;
  assign in_range  = {1'b0, blk} < eff_count;
  assign is_alloc  = (act == fcba_pkg::ACT_ALLOC) || (act == fcba_pkg::ACT_LINK);
  assign is_census = (act == fcba_pkg::ACT_CENSUS);

  // Actions that name a block fail when it is not below the block count.
  always_comb begin
    case (act)
      fcba_pkg::ACT_LOAD, fcba_pkg::ACT_READ, fcba_pkg::ACT_LINK,
      fcba_pkg::ACT_TERM: range_fail = !in_range;
      default:            range_fail = 1'b0;
    endcase
  end

  // Scan pipeline: one read issued per cycle, its registered data checked in the cycle after.
  assign scan_issue = (state == fcba_pkg::S_SCAN) && (cnt < eff_count);
  assign scan_hit   = is_alloc && rd_pending && (rd_data == fcba_pkg::ENTRY_FREE);
  assign scan_end   = !rd_pending && (cnt >= eff_count);

  assign out_take = out_valid && !out_stall;
  assign out_load = (state == fcba_pkg::S_DONE) && (!out_valid || !out_stall);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      fcba_pkg::S_IDLE: begin
        if (in_valid) state_next = fcba_pkg::S_EXEC;
      end
      fcba_pkg::S_EXEC: begin
        if (range_fail) begin
          state_next = fcba_pkg::S_DONE;
        end else begin
          case (act)
            fcba_pkg::ACT_READ:   state_next = fcba_pkg::S_RDWAIT;
            fcba_pkg::ACT_ALLOC,
            fcba_pkg::ACT_LINK,
            fcba_pkg::ACT_CENSUS: state_next = fcba_pkg::S_SCAN;
            default:              state_next = fcba_pkg::S_DONE;
          endcase
        end
      end
      fcba_pkg::S_RDWAIT: state_next = fcba_pkg::S_DONE;
      fcba_pkg::S_SCAN: begin
        if (scan_hit)      state_next = fcba_pkg::S_MARK;
        else if (scan_end) state_next = fcba_pkg::S_DONE;
      end
      fcba_pkg::S_MARK: begin
        state_next = (act == fcba_pkg::ACT_LINK) ? fcba_pkg::S_LINK : fcba_pkg::S_DONE;
      end
      fcba_pkg::S_LINK: state_next = fcba_pkg::S_DONE;
      fcba_pkg::S_DONE: begin
        if (out_load) state_next = fcba_pkg::S_IDLE;
      end
      default: state_next = fcba_pkg::S_IDLE;
    endcase
  end

  // Memory port controls for each state.
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = blk;
    mem_we    = 1'b0;
    mem_waddr = blk;
    mem_wdata = val;
    case (state)
      fcba_pkg::S_EXEC: begin
        if (!range_fail) begin
          case (act)
            fcba_pkg::ACT_LOAD: mem_we = 1'b1;
            fcba_pkg::ACT_READ: mem_re = 1'b1;
            fcba_pkg::ACT_TERM: begin
              mem_we    = 1'b1;
              mem_wdata = fcba_pkg::END_OF_CHAIN;
            end
            default: ;
          endcase
        end
      end
      fcba_pkg::S_SCAN: begin
        mem_re    = scan_issue;
        mem_raddr = cnt[fcba_pkg::IDX_W-1:0];
      end
      fcba_pkg::S_MARK: begin
        mem_we    = 1'b1;
        mem_waddr = res_found;
        mem_wdata = fcba_pkg::ENTRY_TAKEN;
      end
      fcba_pkg::S_LINK: begin
        mem_we    = 1'b1;
        mem_wdata = fcba_pkg::DATA_W'(res_found);
      end
      default: ;
    endcase
  end

  // Table memory with a registered read.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rd_data <= mem[mem_raddr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= fcba_pkg::S_IDLE;
      blocks_in_use <= fcba_pkg::COUNT_RESET;
      rd_pending    <= 1'b0;
      cnt           <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wen) blocks_in_use <= cfg_wdata;
      if (accept) begin
        cnt        <= '0;
        rd_pending <= 1'b0;
      end else if (state == fcba_pkg::S_SCAN) begin
        rd_pending <= scan_issue;
        if (scan_issue) cnt <= cnt + 1'b1;
      end
      if (out_load)      out_valid <= 1'b1;
      else if (out_take) out_valid <= 1'b0;
    end
  end

  // Word capture and result accumulation.
  always_ff @(posedge clk) begin
    if (accept) begin
      act           <= action;
      blk           <= block;
      val           <= value;
      res_status    <= fcba_pkg::ST_OK;
      res_found     <= '0;
      res_entry     <= '0;
      res_free      <= '0;
      res_reserved  <= '0;
      res_allocated <= '0;
    end else begin
      case (state)
        fcba_pkg::S_EXEC: begin
          if (range_fail) res_status <= fcba_pkg::ST_RANGE;
        end
        fcba_pkg::S_RDWAIT: res_entry <= rd_data;
        fcba_pkg::S_SCAN: begin
          if (scan_issue) rd_idx <= cnt[fcba_pkg::IDX_W-1:0];
          if (scan_hit) begin
            res_found <= rd_idx;
          end else if (is_alloc && scan_end) begin
            res_status <= fcba_pkg::ST_NOFREE;
          end
          if (is_census && rd_pending) begin
            if (rd_data == fcba_pkg::ENTRY_FREE)       res_free      <= res_free + 1'b1;
            else if (rd_data == fcba_pkg::ENTRY_TAKEN) res_reserved  <= res_reserved + 1'b1;
            else                                       res_allocated <= res_allocated + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      status          <= res_status;
      found_index     <= res_found;
      entry_value     <= res_entry;
      free_count      <= res_free;
      reserved_count  <= res_reserved;
      allocated_count <= res_allocated;
    end
  end

  // A failed allocation never reports an index or an entry.
  a_nofree_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == fcba_pkg::ST_NOFREE) |-> (found_index == '0) && (entry_value == '0))
    else $error("failed allocation carries data");

  // The scan never runs past the block count.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == fcba_pkg::S_SCAN) |-> (cnt <= eff_count))
    else $error("scan counter beyond block count");

  // The table is never written while it is being scanned.
  a_scan_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == fcba_pkg::S_SCAN) |-> !mem_we)
    else $error("table written during scan");

  // A taken word closes the input and puts the sequencer in execute.
  a_accept_stalls: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall && (state == fcba_pkg::S_EXEC))
    else $error("input not closed after accept");

endmodule
